@@ hdl/hcsdf_pkg.sv @@
// Shared types, widths and arithmetic helpers for the hollow cylinder distance block.
// No dependencies; used by every module under hdl.
package hcsdf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 31;
    localparam int LEN_W      = 30;
    localparam int SHIFT_W    = 4;
    localparam int DIST_W     = 32;
    localparam int GRAD_W     = 19;
    localparam int MAG_W      = 31;
    localparam int RAD_IN_W   = 64;
    localparam int ROOT_W     = RAD_IN_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SIDE_W     = ROOT_W + 3;
    localparam int DIFF_W     = SIDE_W + 1;
    localparam int GRAD_WIDE  = DIFF_W + FRAC_BITS;

    typedef logic [RAD_IN_W-1:0] t_rad_in;
    typedef logic [MAG_W-1:0]    t_mag;

    typedef struct packed {
        t_rad_in n0;
        t_rad_in n1;
        t_rad_in n2;
        t_mag    az;
        t_mag    azs;
    } t_front;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [ROOT_W-1:0]   root;
        logic [RAD_IN_W-1:0] n;
    } t_sqrt_st;

    function automatic t_mag abs_mag(input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] neg;
        neg = -v;
        return v[COORD_W] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // One digit of the restoring square root: bring down two radicand bits.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        t_sqrt_st         o;
        logic [REM_W-1:0] nr;
        logic [REM_W-1:0] t;
        nr = {s.rem[REM_W-3:0], s.n[RAD_IN_W-1 -: 2]};
        t  = {s.root, 2'b01};
        o.n = {s.n[RAD_IN_W-3:0], 2'b00};
        if (nr >= t) begin
            o.rem  = nr - t;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = nr;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Scale a distance difference by 2^(FRAC_BITS-k), floor, then saturate.
    function automatic logic [GRAD_W-1:0] grad_scale(input logic signed [DIFF_W-1:0] d,
                                                     input logic [SHIFT_W-1:0] k);
        logic signed [GRAD_WIDE-1:0] w;
        logic signed [GRAD_WIDE-1:0] gmax;
        logic signed [GRAD_WIDE-1:0] gmin;
        w    = GRAD_WIDE'(d);
        gmax = GRAD_WIDE'(signed'({1'b0, {(GRAD_W-1){1'b1}}}));
        gmin = -gmax - GRAD_WIDE'(1);
        if (int'(k) <= FRAC_BITS) begin
            w = w <<< (FRAC_BITS - int'(k));
        end else begin
            w = w >>> (int'(k) - FRAC_BITS);
        end
        if (w > gmax) begin
            w = gmax;
        end else if (w < gmin) begin
            w = gmin;
        end
        return w[GRAD_W-1:0];
    endfunction

endpackage

@@ hdl/hcsdf_front.sv @@
// Front stages: step offsets, magnitudes, squares and radicand sums.
// Depends on hcsdf_pkg.
module hcsdf_front (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_x,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_y,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_z,
    input  logic [hcsdf_pkg::SHIFT_W-1:0]        i_k,
    output hcsdf_pkg::t_front                    o_front
);
    localparam int CW = hcsdf_pkg::COORD_W + 1;
    localparam int SQ = 2 * hcsdf_pkg::MAG_W;

    logic signed [CW-1:0] step;
    logic signed [CW-1:0] xs, ys, zs;
    hcsdf_pkg::t_mag r_ax, r_ay, r_axs, r_ays, r_az1, r_azs1;
    hcsdf_pkg::t_mag r_az2, r_azs2;
    logic [SQ-1:0] r_sx, r_sy, r_sxs, r_sys;
    hcsdf_pkg::t_front r_out;

    assign step = CW'(1) <<< i_k;
    assign xs   = CW'(i_x) + step;
    assign ys   = CW'(i_y) + step;
    assign zs   = CW'(i_z) + step;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= hcsdf_pkg::abs_mag(CW'(i_x));
            r_ay   <= hcsdf_pkg::abs_mag(CW'(i_y));
            r_axs  <= hcsdf_pkg::abs_mag(xs);
            r_ays  <= hcsdf_pkg::abs_mag(ys);
            r_az1  <= hcsdf_pkg::abs_mag(CW'(i_z));
            r_azs1 <= hcsdf_pkg::abs_mag(zs);

            r_sx   <= SQ'(r_ax)  * SQ'(r_ax);
            r_sy   <= SQ'(r_ay)  * SQ'(r_ay);
            r_sxs  <= SQ'(r_axs) * SQ'(r_axs);
            r_sys  <= SQ'(r_ays) * SQ'(r_ays);
            r_az2  <= r_az1;
            r_azs2 <= r_azs1;

            r_out.n0  <= hcsdf_pkg::RAD_IN_W'(r_sx)  + hcsdf_pkg::RAD_IN_W'(r_sy);
            r_out.n1  <= hcsdf_pkg::RAD_IN_W'(r_sxs) + hcsdf_pkg::RAD_IN_W'(r_sy);
            r_out.n2  <= hcsdf_pkg::RAD_IN_W'(r_sx)  + hcsdf_pkg::RAD_IN_W'(r_sys);
            r_out.az  <= r_az2;
            r_out.azs <= r_azs2;
        end
    end

    assign o_front = r_out;
endmodule

@@ hdl/hcsdf_isqrt.sv @@
// Pipelined floor integer square root, one root bit per stage.
// Depends on hcsdf_pkg.
module hcsdf_isqrt (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [hcsdf_pkg::RAD_IN_W-1:0]      i_n,
    output logic [hcsdf_pkg::ROOT_W-1:0]        o_root
);
    localparam int NST = hcsdf_pkg::ROOT_W;

    hcsdf_pkg::t_sqrt_st r_st [NST];
    hcsdf_pkg::t_sqrt_st seed;

    assign seed.rem  = '0;
    assign seed.root = '0;
    assign seed.n    = i_n;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= hcsdf_pkg::sqrt_step(seed);
        end
    end

    for (genvar g = 1; g < NST; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= hcsdf_pkg::sqrt_step(r_st[g-1]);
            end
        end
    end

    assign o_root = r_st[NST-1].root;
endmodule

@@ hdl/hollow_cylinder_sdf_with_gradient.sv @@
// Hollow cylinder signed distance with forward-difference gradient.
// Throughput one point per cycle while the pipeline is not stalled.
// Depth is set by the 32-stage square root pipeline plus three front and three back stages.
// The whole pipeline holds while a result waits and the output side is not ready.
// Synchronous active-low reset clears the valid bits and the configuration registers.
module hollow_cylinder_sdf_with_gradient (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [hcsdf_pkg::COORD_W-1:0] i_point_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [hcsdf_pkg::DIST_W-1:0] o_signed_distance,
    output logic signed [hcsdf_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [hcsdf_pkg::GRAD_W-1:0] o_grad_y,
    output logic signed [hcsdf_pkg::GRAD_W-1:0] o_grad_z
);
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd0;
    localparam logic [1:0] REG_RADIUS      = 2'd1;
    localparam logic [1:0] REG_HALF_THICK  = 2'd2;
    localparam logic [1:0] REG_STEP_SHIFT  = 2'd3;

    localparam int FRONT_LAT = 3;
    localparam int SQRT_LAT  = hcsdf_pkg::ROOT_W;
    localparam int LAT       = FRONT_LAT + SQRT_LAT + 3;
    localparam int SW        = hcsdf_pkg::SIDE_W;
    localparam int DW        = hcsdf_pkg::DIFF_W;

    logic [hcsdf_pkg::LEN_W-1:0]   r_half_height, r_radius, r_half_thick;
    logic [hcsdf_pkg::SHIFT_W-1:0] r_step_shift;
    logic                          wr;
    logic                          en;
    logic [LAT-1:0]                r_vld;

    hcsdf_pkg::t_front front;
    logic [hcsdf_pkg::ROOT_W-1:0] root0, root1, root2;
    hcsdf_pkg::t_mag r_az [SQRT_LAT];
    hcsdf_pkg::t_mag r_azs [SQRT_LAT];

    logic signed [SW-1:0] r_side0, r_side1, r_side2, r_cap0, r_cap1;
    logic signed [SW-1:0] d0, dx, dy, dz;
    logic signed [SW-1:0] r_d0;
    logic signed [DW-1:0] r_gx, r_gy, r_gz;
    logic signed [hcsdf_pkg::DIST_W-1:0] r_dist;
    logic [hcsdf_pkg::GRAD_W-1:0] r_ox, r_oy, r_oz;

    // Configuration port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_height <= '0;
            r_radius      <= '0;
            r_half_thick  <= '0;
            r_step_shift  <= '0;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_HALF_HEIGHT: r_half_height <= pwdata[hcsdf_pkg::LEN_W-1:0];
                REG_RADIUS:      r_radius      <= pwdata[hcsdf_pkg::LEN_W-1:0];
                REG_HALF_THICK:  r_half_thick  <= pwdata[hcsdf_pkg::LEN_W-1:0];
                REG_STEP_SHIFT:  r_step_shift  <= pwdata[hcsdf_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HALF_HEIGHT: prdata = 32'(r_half_height);
            REG_RADIUS:      prdata = 32'(r_radius);
            REG_HALF_THICK:  prdata = 32'(r_half_thick);
            REG_STEP_SHIFT:  prdata = 32'(r_step_shift);
            default:         prdata = '0;
        endcase
    end

    // Advance every stage unless the result register is full and held
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    hcsdf_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_k     (r_step_shift),
        .o_front (front)
    );

    hcsdf_isqrt u_sqrt0 (.i_clk(i_clk), .i_en(en), .i_n(front.n0), .o_root(root0));
    hcsdf_isqrt u_sqrt1 (.i_clk(i_clk), .i_en(en), .i_n(front.n1), .o_root(root1));
    hcsdf_isqrt u_sqrt2 (.i_clk(i_clk), .i_en(en), .i_n(front.n2), .o_root(root2));

    // Carry the z magnitudes alongside the root pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_az[0]  <= front.az;
            r_azs[0] <= front.azs;
            for (int i = 1; i < SQRT_LAT; i++) begin
                r_az[i]  <= r_az[i-1];
                r_azs[i] <= r_azs[i-1];
            end
        end
    end

    function automatic logic signed [SW-1:0] side_dist(
        input logic [hcsdf_pkg::ROOT_W-1:0] r,
        input logic [hcsdf_pkg::LEN_W-1:0]  rad,
        input logic [hcsdf_pkg::LEN_W-1:0]  th);
        logic signed [SW-1:0] d;
        d = signed'(SW'(r)) - signed'(SW'(rad));
        if (d < 0) begin
            d = -d;
        end
        return d - signed'(SW'(th));
    endfunction

    assign d0 = (r_side0 > r_cap0) ? r_side0 : r_cap0;
    assign dx = (r_side1 > r_cap0) ? r_side1 : r_cap0;
    assign dy = (r_side2 > r_cap0) ? r_side2 : r_cap0;
    assign dz = (r_side0 > r_cap1) ? r_side0 : r_cap1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0 <= side_dist(root0, r_radius, r_half_thick);
            r_side1 <= side_dist(root1, r_radius, r_half_thick);
            r_side2 <= side_dist(root2, r_radius, r_half_thick);
            r_cap0  <= signed'(SW'(r_az[SQRT_LAT-1]))  - signed'(SW'(r_half_height));
            r_cap1  <= signed'(SW'(r_azs[SQRT_LAT-1])) - signed'(SW'(r_half_height));

            r_d0 <= d0;
            r_gx <= DW'(dx) - DW'(d0);
            r_gy <= DW'(dy) - DW'(d0);
            r_gz <= DW'(dz) - DW'(d0);

            r_dist <= r_d0[hcsdf_pkg::DIST_W-1:0];
            r_ox   <= hcsdf_pkg::grad_scale(r_gx, r_step_shift);
            r_oy   <= hcsdf_pkg::grad_scale(r_gy, r_step_shift);
            r_oz   <= hcsdf_pkg::grad_scale(r_gz, r_step_shift);
        end
    end

    assign o_valid           = r_vld[LAT-1];
    assign o_signed_distance = r_dist;
    assign o_grad_x          = signed'(r_ox);
    assign o_grad_y          = signed'(r_oy);
    assign o_grad_z          = signed'(r_oz);

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_signed_distance) && $stable(o_grad_x))
        else $error("held result changed");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the hollow cylinder distance and gradient block.
// Depends on hdl/hcsdf_pkg.sv and hdl/hollow_cylinder_sdf_with_gradient.sv.
module testbench;

    localparam int LATENCY = 38;
    localparam logic [3:0] ADDR_HALF_HEIGHT    = 4'd0;
    localparam logic [3:0] ADDR_RADIUS         = 4'd4;
    localparam logic [3:0] ADDR_HALF_THICKNESS = 4'd8;
    localparam logic [3:0] ADDR_STEP_SHIFT     = 4'd12;
    localparam longint CMAX = 64'sd1073741823;
    localparam longint CMIN = -64'sd1073741824;

    typedef struct packed {
        logic signed [hcsdf_pkg::DIST_W-1:0] sdist;
        logic signed [hcsdf_pkg::GRAD_W-1:0] gx;
        logic signed [hcsdf_pkg::GRAD_W-1:0] gy;
        logic signed [hcsdf_pkg::GRAD_W-1:0] gz;
    } t_sdf_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [hcsdf_pkg::COORD_W-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [hcsdf_pkg::DIST_W-1:0] o_signed_distance;
    logic signed [hcsdf_pkg::GRAD_W-1:0] o_grad_x, o_grad_y, o_grad_z;

    hollow_cylinder_sdf_with_gradient i_dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow copy of the configuration
    longint cfg_height, cfg_radius, cfg_thick;
    int     cfg_shift;

    t_sdf_result pending_results[$];
    int errors = 0;
    int points_sent = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    function automatic longint iroot(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint shell_dist(longint x, longint y, longint z);
        longint unsigned ax = labs(x);
        longint unsigned ay = labs(y);
        longint rxy = iroot(ax * ax + ay * ay);
        longint side = labs(rxy - cfg_radius) - cfg_thick;
        longint cap = labs(z) - cfg_height;
        return side > cap ? side : cap;
    endfunction

    function automatic logic [hcsdf_pkg::GRAD_W-1:0] slope(longint diff);
        longint g;
        if (cfg_shift <= hcsdf_pkg::FRAC_BITS)
            g = diff * (64'sd1 <<< (hcsdf_pkg::FRAC_BITS - cfg_shift));
        else g = diff >>> (cfg_shift - hcsdf_pkg::FRAC_BITS);
        if (g > 262143) g = 262143;
        if (g < -262144) g = -262144;
        return g[hcsdf_pkg::GRAD_W-1:0];
    endfunction

    function automatic t_sdf_result predict_sdf(longint x, longint y, longint z);
        t_sdf_result r;
        longint s = 64'sd1 <<< cfg_shift;
        longint d0 = shell_dist(x, y, z);
        r.sdist = d0[hcsdf_pkg::DIST_W-1:0];
        r.gx = slope(shell_dist(x + s, y, z) - d0);
        r.gy = slope(shell_dist(x, y + s, z) - d0);
        r.gz = slope(shell_dist(x, y, z + s) - d0);
        return r;
    endfunction

    // setup then access; the caller releases the bus after the last write
    task automatic write_reg(logic [3:0] addr, logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (addr)
            ADDR_HALF_HEIGHT:    cfg_height = value[hcsdf_pkg::LEN_W-1:0];
            ADDR_RADIUS:         cfg_radius = value[hcsdf_pkg::LEN_W-1:0];
            ADDR_HALF_THICKNESS: cfg_thick  = value[hcsdf_pkg::LEN_W-1:0];
            ADDR_STEP_SHIFT:     cfg_shift  = value[hcsdf_pkg::SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard = 0;
        i_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_shape(logic [29:0] h, logic [29:0] r, logic [29:0] t, logic [3:0] k);
        drain();
        write_reg(ADDR_HALF_HEIGHT, {2'b0, h});
        write_reg(ADDR_RADIUS, {2'b0, r});
        write_reg(ADDR_HALF_THICKNESS, {2'b0, t});
        write_reg(ADDR_STEP_SHIFT, {28'b0, k});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays high after a transfer until the next idle cycle or drain
    task automatic send_point(longint x, longint y, longint z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x[hcsdf_pkg::COORD_W-1:0];
        i_point_y <= y[hcsdf_pkg::COORD_W-1:0];
        i_point_z <= z[hcsdf_pkg::COORD_W-1:0];
        pending_results.push_back(predict_sdf(x, y, z));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        points_sent++;
    endtask

    function automatic longint rand_coord(int mode);
        case (mode)
            0: return longint'($urandom_range(2147483647)) - 64'sd1073741824;
            1: return longint'($urandom_range(2000000)) - 1000000;
            default: return longint'($urandom_range(400)) - 200;
        endcase
    endfunction

    task automatic test_directed();
        longint c[5];
        c = '{CMIN, CMAX, 0, -1, 1};
        set_shape(30'd65536, 30'd131072, 30'd16384, 4'd0);
        for (int i = 0; i < 5; i++) send_point(c[i], c[4 - i], c[(i + 2) % 5]);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(131072, 0, 0);     // on the wall mid-surface
        send_point(0, 0, 65536);      // on the cap plane
        set_shape(30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 4'd15);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(-5, 3, -7);        // coarsest step scales differences by two
        set_shape(30'd0, 30'd0, 30'd0, 4'd0);
        send_point(0, 0, 0);
        send_point(CMAX, 0, CMIN);
        set_shape(30'd0, 30'd1000, 30'd0, 4'd15);
        send_point(-1000, 0, 0);
        send_point(CMIN, CMAX, 0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            int mode = $urandom_range(2);
            if (i % 100 == 0)
                set_shape(30'($urandom_range(mode == 0 ? 30'h3FFFFFFF : 30'd300)),
                          30'($urandom_range(mode == 0 ? 30'h3FFFFFFF : 30'd300)),
                          30'($urandom_range(mode == 0 ? 30'h3FFFFFFF : 30'd100)),
                          4'($urandom_range(15)));
            send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 120;
        for (int i = 0; i < 80; i++) send_point(rand_coord(1), rand_coord(1), rand_coord(2));
        drain();
        for (int i = 0; i < 20; i++) send_point(rand_coord(0), rand_coord(2), rand_coord(1));
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending");
                errors++;
            end else begin
                t_sdf_result e;
                e = pending_results.pop_front();
                if (o_signed_distance !== e.sdist) begin
                    $error("signed_distance expected %0d got %0d", e.sdist, o_signed_distance);
                    errors++;
                end
                if (o_grad_x !== e.gx) begin
                    $error("grad_x expected %0d got %0d", e.gx, o_grad_x);
                    errors++;
                end
                if (o_grad_y !== e.gy) begin
                    $error("grad_y expected %0d got %0d", e.gy, o_grad_y);
                    errors++;
                end
                if (o_grad_z !== e.gz) begin
                    $error("grad_z expected %0d got %0d", e.gz, o_grad_z);
                    errors++;
                end
            end
            results_seen++;
        end
    end

    initial begin
        cfg_height = 0; cfg_radius = 0; cfg_thick = 0; cfg_shift = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 11; recv_idle_pct = 54;
        test_directed();
        test_random(400);
        send_idle_pct = 54; recv_idle_pct = 11;
        test_random(400);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(350);
        drain();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("sent %0d points, checked %0d results over random shapes and steps",
                 points_sent, results_seen);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
